### sv/bmsi_pkg.sv
// Shared widths, codes and limits for the bank mapper with scanline interrupt.
package bmsi_pkg;

  // Field widths of the bus access and result words.
  localparam int OP_W      = 2;
  localparam int ADDR_W    = 16;
  localparam int DATA_W    = 8;
  localparam int TGT_W     = 2;
  localparam int OFS_W     = 19;
  localparam int PRG_CNT_W = 7;
  localparam int CHR_CNT_W = 9;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 9;

  // Bank count limits.
  localparam int MAX_PRG_BANKS = 64;
  localparam int MAX_CHR_BANKS = 256;
  localparam int MIN_PRG_BANKS = 2;
  localparam int MIN_CHR_BANKS = 8;

  // Bank page sizes as address bit counts (8KB program, 1KB pattern).
  localparam int PRG_PAGE_W = 13;
  localparam int CHR_PAGE_W = 10;

  // Bus operation codes.
  localparam logic [OP_W-1:0] OP_CPU_READ  = 2'd0;
  localparam logic [OP_W-1:0] OP_CPU_WRITE = 2'd1;
  localparam logic [OP_W-1:0] OP_PPU_READ  = 2'd2;
  localparam logic [OP_W-1:0] OP_PPU_WRITE = 2'd3;

  // Target store codes.
  localparam logic [TGT_W-1:0] TGT_NONE = 2'd0;
  localparam logic [TGT_W-1:0] TGT_WRAM = 2'd1;
  localparam logic [TGT_W-1:0] TGT_PRG  = 2'd2;
  localparam logic [TGT_W-1:0] TGT_CHR  = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PRG_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHR_COUNT = 1'd1;

  // Mapper register codes: address bits 15:13 and bit 0.
  typedef enum logic [3:0] {
    REG_BANK_SELECT = 4'b1000,
    REG_BANK_DATA   = 4'b1001,
    REG_MIRROR      = 4'b1010,
    REG_PROTECT     = 4'b1011,
    REG_IRQ_LATCH   = 4'b1100,
    REG_IRQ_RELOAD  = 4'b1101,
    REG_IRQ_DISABLE = 4'b1110,
    REG_IRQ_ENABLE  = 4'b1111
  } reg_code_t;

endpackage

### sv/bank_mapper_with_scanline_irq_top.sv
// Bank mapper with scanline interrupt: register decode, bank mapping and counter.
//
//   Channel | Direction | Handshake          | Word
//   --------+-----------+--------------------+------------------------------------------
//   in      | input     | in_valid/in_stall  | operation, bus_address, write_data
//   out     | output    | out_valid/out_stall| target, physical_offset, access_allowed,
//           |           |                    | mirror_horizontal, irq_pending
//   cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Each word is accepted, then passes through the shared restoring remainder
// unit that reduces the bank number modulo the bank count (one bit per
// cycle), and then the result is formed and the mapper registers are updated.
// The result sits in an output register, so the next word is accepted while a
// result waits; a stalled output holds the block in its finish cycle.
// Synchronous reset clears all mapper registers and sets the bank counts to 4
// program and 8 pattern banks. Configuration writes are always taken.
module bank_mapper_with_scanline_irq_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [bmsi_pkg::OP_W-1:0]          operation,
  input  logic [bmsi_pkg::ADDR_W-1:0]        bus_address,
  input  logic [bmsi_pkg::DATA_W-1:0]        write_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [bmsi_pkg::TGT_W-1:0]         target,
  output logic [bmsi_pkg::OFS_W-1:0]         physical_offset,
  output logic                               access_allowed,
  output logic                               mirror_horizontal,
  output logic                               irq_pending,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bmsi_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bmsi_pkg::CFG_DAT_W-1:0]     cfg_data
);

  import bmsi_pkg::*;

  localparam int BANK_W = DATA_W;
  localparam int STEP_W = $clog2(BANK_W);
  localparam int DIV_W  = CHR_CNT_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIVIDE,
    S_FINISH
  } state_t;

  state_t state;

  // Configuration registers.
  logic [PRG_CNT_W-1:0] prg_count;
  logic [CHR_CNT_W-1:0] chr_count;

  // Mapper state.
  logic [DATA_W-1:0] bank_select;
  logic [DATA_W-1:0] bank_regs [8];
  logic              mirroring_bit;
  logic              ram_protected;
  logic [DATA_W-1:0] irq_reload_value;
  logic [DATA_W-1:0] scanline_counter;
  logic              irq_enable;
  logic              previous_a12;
  logic              irq_flag;

  // Captured access and remainder unit.
  logic [OP_W-1:0]   op_q;
  logic [ADDR_W-1:0] addr_q;
  logic [DATA_W-1:0] data_q;
  logic [BANK_W-1:0] dividend;
  logic [DIV_W-1:0]  divisor;
  logic [DIV_W-1:0]  rem;
  logic [STEP_W-1:0] step;

  // Next values of mapper state.
  logic [DATA_W-1:0] bank_select_next;
  logic [DATA_W-1:0] bank_regs_next [8];
  logic              mirroring_bit_next;
  logic              ram_protected_next;
  logic [DATA_W-1:0] irq_reload_value_next;
  logic [DATA_W-1:0] scanline_counter_next;
  logic              irq_enable_next;
  logic              previous_a12_next;
  logic              irq_flag_next;

  logic [PRG_CNT_W-1:0] prg_eff;
  logic [CHR_CNT_W-1:0] chr_eff;
  logic                 is_ppu;
  logic [1:0]           prg_slot;
  logic [2:0]           chr_slot;
  logic [2:0]           chr_idx;
  logic [BANK_W-1:0]    prg_bank;
  logic [BANK_W-1:0]    chr_bank;
  logic [DIV_W-1:0]     trial;
  logic                 trial_fits;
  logic                 load_out;
  logic [TGT_W-1:0]     tgt_calc;
  logic [OFS_W-1:0]     ofs_calc;
  logic                 allowed_calc;
  logic [DATA_W-1:0]    count_step;
  reg_code_t            reg_code;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign load_out  = (state == S_FINISH) && (!out_valid || !out_stall);

  // Bank counts clamped to their legal ranges.
  always_comb begin
    if (prg_count < PRG_CNT_W'(MIN_PRG_BANKS)) begin
      prg_eff = PRG_CNT_W'(MIN_PRG_BANKS);
    end else if (prg_count > PRG_CNT_W'(MAX_PRG_BANKS)) begin
      prg_eff = PRG_CNT_W'(MAX_PRG_BANKS);
    end else begin
      prg_eff = prg_count;
    end
    if (chr_count < CHR_CNT_W'(MIN_CHR_BANKS)) begin
      chr_eff = CHR_CNT_W'(MIN_CHR_BANKS);
    end else if (chr_count > CHR_CNT_W'(MAX_CHR_BANKS)) begin
      chr_eff = CHR_CNT_W'(MAX_CHR_BANKS);
    end else begin
      chr_eff = chr_count;
    end
  end

  // Raw bank number for the incoming access, before reduction.
  always_comb begin
    is_ppu   = operation[1];
    prg_slot = bus_address[PRG_PAGE_W+1:PRG_PAGE_W];
    if (prg_slot == 2'd1) begin
      prg_bank = bank_regs[7];
    end else if (prg_slot == 2'd3) begin
      prg_bank = BANK_W'(prg_eff - PRG_CNT_W'(1));
    end else if ((prg_slot == 2'd0) != bank_select[6]) begin
      prg_bank = bank_regs[6];
    end else begin
      prg_bank = BANK_W'(prg_eff - PRG_CNT_W'(2));
    end
    // Pattern inversion swaps the 2KB and 1KB halves.
    chr_slot = bus_address[CHR_PAGE_W+2:CHR_PAGE_W] ^ {bank_select[7], 2'b00};
    chr_idx  = chr_slot[2] ? (chr_slot - 3'd2) : {2'b00, chr_slot[1]};
    if (chr_slot[2]) begin
      chr_bank = bank_regs[chr_idx];
    end else begin
      chr_bank = (bank_regs[chr_idx] & 8'hFE) | {7'd0, chr_slot[0]};
    end
  end

  // Shared remainder step: shift in one dividend bit, subtract if it fits.
  assign trial      = {rem[DIV_W-2:0], dividend[BANK_W-1]};
  assign trial_fits = (trial >= divisor);

  // Result word from the captured access and the reduced bank number.
  always_comb begin
    tgt_calc     = TGT_NONE;
    ofs_calc     = '0;
    allowed_calc = 1'b0;
    if (!op_q[1]) begin
      if (addr_q[15]) begin
        tgt_calc     = TGT_PRG;
        ofs_calc     = OFS_W'({rem, addr_q[PRG_PAGE_W-1:0]});
        allowed_calc = (op_q == OP_CPU_READ);
      end else if (addr_q[14:13] == 2'b11) begin
        tgt_calc     = TGT_WRAM;
        ofs_calc     = OFS_W'(addr_q[PRG_PAGE_W-1:0]);
        allowed_calc = !ram_protected;
      end
    end else if (addr_q[15:13] == 3'b000) begin
      tgt_calc     = TGT_CHR;
      ofs_calc     = OFS_W'({rem, addr_q[CHR_PAGE_W-1:0]});
      allowed_calc = 1'b1;
    end
  end

  // Register writes and scanline counter clocking for the captured access.
  always_comb begin
    bank_select_next      = bank_select;
    bank_regs_next        = bank_regs;
    mirroring_bit_next    = mirroring_bit;
    ram_protected_next    = ram_protected;
    irq_reload_value_next = irq_reload_value;
    scanline_counter_next = scanline_counter;
    irq_enable_next       = irq_enable;
    previous_a12_next     = previous_a12;
    irq_flag_next         = irq_flag;
    reg_code              = reg_code_t'({addr_q[15:13], addr_q[0]});
    count_step            = (scanline_counter == '0) ? irq_reload_value
                                                     : scanline_counter - DATA_W'(1);
    if (op_q == OP_CPU_WRITE && addr_q[15]) begin
      unique case (reg_code)
        REG_BANK_SELECT: bank_select_next = data_q;
        REG_BANK_DATA:   bank_regs_next[bank_select[2:0]] = data_q;
        REG_MIRROR:      mirroring_bit_next = data_q[0];
        REG_PROTECT:     ram_protected_next = !data_q[3];
        REG_IRQ_LATCH:   irq_reload_value_next = data_q;
        REG_IRQ_RELOAD:  scanline_counter_next = '0;
        REG_IRQ_DISABLE: begin
          irq_enable_next = 1'b0;
          irq_flag_next   = 1'b0;
        end
        REG_IRQ_ENABLE:  irq_enable_next = 1'b1;
        default:         irq_enable_next = irq_enable;
      endcase
    end
    if (op_q[1]) begin
      // A rising A12 steps the counter.
      if (!previous_a12 && addr_q[12]) begin
        scanline_counter_next = count_step;
        if (count_step == '0 && irq_enable) begin
          irq_flag_next = 1'b1;
        end
      end
      previous_a12_next = addr_q[12];
    end
  end

  // Sequencer, mapper registers and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      prg_count        <= PRG_CNT_W'(4);
      chr_count        <= CHR_CNT_W'(8);
      bank_select      <= '0;
      for (int i = 0; i < 8; i++) begin
        bank_regs[i] <= '0;
      end
      mirroring_bit    <= 1'b0;
      ram_protected    <= 1'b0;
      irq_reload_value <= '0;
      scanline_counter <= '0;
      irq_enable       <= 1'b0;
      previous_a12     <= 1'b0;
      irq_flag         <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      // Configuration writes.
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_PRG_COUNT: prg_count <= cfg_data[PRG_CNT_W-1:0];
          CFG_CHR_COUNT: chr_count <= cfg_data[CHR_CNT_W-1:0];
          default:       prg_count <= prg_count;
        endcase
      end
      // Output valid rises with a new result and falls once the result is taken.
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_q     <= operation;
            addr_q   <= bus_address;
            data_q   <= write_data;
            dividend <= is_ppu ? chr_bank : prg_bank;
            divisor  <= is_ppu ? chr_eff : DIV_W'(prg_eff);
            rem      <= '0;
            step     <= '0;
            state    <= S_DIVIDE;
          end
        end
        S_DIVIDE: begin
          rem      <= trial_fits ? (trial - divisor) : trial;
          dividend <= {dividend[BANK_W-2:0], 1'b0};
          step     <= step + STEP_W'(1);
          if (step == STEP_W'(BANK_W - 1)) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (load_out) begin
            target            <= tgt_calc;
            physical_offset   <= ofs_calc;
            access_allowed    <= allowed_calc;
            mirror_horizontal <= mirroring_bit_next;
            irq_pending       <= irq_flag_next;
            bank_select       <= bank_select_next;
            bank_regs         <= bank_regs_next;
            mirroring_bit     <= mirroring_bit_next;
            ram_protected     <= ram_protected_next;
            irq_reload_value  <= irq_reload_value_next;
            scanline_counter  <= scanline_counter_next;
            irq_enable        <= irq_enable_next;
            previous_a12      <= previous_a12_next;
            irq_flag          <= irq_flag_next;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The partial remainder always stays below the divisor.
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIVIDE) |-> (rem < divisor))
    else $error("remainder reached the divisor");

  // An accepted word keeps the block busy for the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("block not busy after accepting a word");

  // The interrupt flag only rises while interrupts are enabled.
  a_irq_needs_enable: assert property (@(posedge clk) disable iff (rst)
    $rose(irq_flag) |-> irq_enable)
    else $error("interrupt flag set while disabled");

  // A new result only comes out of the finish cycle.
  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FINISH))
    else $error("result produced outside the finish cycle");

endmodule
